[rtl/slt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the command line tokenizer
// Lexer modes, token kinds, character codes and the token record that
// travels from the lexer front end to the token queue.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int LINE_BYTES  = 1024;
  localparam int POS_W       = $clog2(LINE_BYTES) + 1;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 4;
  localparam int START_W     = 10;
  localparam int LEN_W       = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_WORD     = 4'd1,
    MODE_WORD_ESC = 4'd2,
    MODE_SQ       = 4'd3,
    MODE_DQ       = 4'd4,
    MODE_DQ_ESC   = 4'd5,
    MODE_COMMENT  = 4'd6,
    MODE_GT       = 4'd7,
    MODE_AMP      = 4'd8,
    MODE_BAR      = 4'd9
  } lex_mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WORD = 4'd0,
    KIND_GT   = 4'd1,
    KIND_GTGT = 4'd2,
    KIND_LT   = 4'd3,
    KIND_LP   = 4'd4,
    KIND_RP   = 4'd5,
    KIND_AMP  = 4'd6,
    KIND_AND  = 4'd7,
    KIND_BAR  = 4'd8,
    KIND_OR   = 4'd9,
    KIND_SEMI = 4'd10,
    KIND_END  = 4'd11
  } token_kind_t;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DQUOT = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
  localparam logic [BYTE_W-1:0] CH_SQUOT = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_BAR   = 8'h7C;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               overflow;
    logic               last;
  } token_t;

  // up to two tokens leave the lexer per byte, in order a then b
  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } token_push_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] ch);
    return (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR) ||
           (ch == CH_TAB) || (ch == CH_FF);
  endfunction

  function automatic logic is_symbol(input logic [BYTE_W-1:0] ch);
    return (ch == CH_LT) || (ch == CH_GT) || (ch == CH_AMP) || (ch == CH_BAR) ||
           (ch == CH_SEMI) || (ch == CH_LPAR) || (ch == CH_RPAR);
  endfunction

endpackage

[rtl/slt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_byte_if / slt_token_if: ready/valid channels of the tokenizer
// One carries line bytes in, the other carries tokens out.
// ----------------------------------------------------------------------------
interface slt_byte_if;
  import slt_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface slt_token_if;
  import slt_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [START_W-1:0] token_start;
  logic [LEN_W-1:0]   token_length;
  logic               overflow;
  logic               last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output overflow, output last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input overflow, input last, output ready);
endinterface

[rtl/slt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_front: lexer front end
// Takes one byte per cycle while the token queue has space, runs the lexer
// state machine and hands zero, one or two finished tokens to the queue.
// ----------------------------------------------------------------------------
module slt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  input  logic [slt_pkg::BYTE_W-1:0] line_byte,
  output logic                       ready,
  input  logic                       queue_space,
  output slt_pkg::token_push_t       push
);
  import slt_pkg::*;

  localparam logic [POS_W-1:0] LB = POS_W'(LINE_BYTES);

  lex_mode_t          mode, mode_next;
  logic [START_W-1:0] cur_start, cur_start_next;
  logic [POS_W-1:0]   line_pos, line_pos_next;
  logic               ovf_seen, ovf_seen_next;

  logic               accept;
  logic               sat, ovf_now;
  logic [POS_W-1:0]   spos, epos, pos_adv, qpos, cur_ext, span;

  // first phase: token finished by the current mode
  logic               a_emit;
  token_kind_t        a_kind;
  logic [START_W-1:0] a_start;
  logic [LEN_W-1:0]   a_len;
  logic               do_start;
  lex_mode_t          mode_after;
  token_kind_t        k1;
  logic [BYTE_W-1:0]  dbl;

  // second phase: the byte taken as the start of a new token
  logic               b_emit;
  token_kind_t        b_kind;
  logic [LEN_W-1:0]   b_len;
  lex_mode_t          s_mode;
  logic               s_set_start;
  logic [START_W-1:0] s_start_val;
  logic               line_end;

  assign ready  = queue_space;
  assign accept = valid && ready;

  // positions, saturated at the line limit
  always_comb begin
    sat     = (line_pos >= LB);
    ovf_now = ovf_seen || sat;
    spos    = sat ? LB - POS_W'(1) : line_pos;
    epos    = sat ? LB : line_pos;
    pos_adv = sat ? line_pos : line_pos + POS_W'(1);
    qpos    = ((spos + POS_W'(1)) < LB) ? spos + POS_W'(1) : LB - POS_W'(1);
    cur_ext = POS_W'(cur_start);
    span    = (epos > cur_ext) ? epos - cur_ext : '0;
  end

  // pending operator: what doubles it and its single kind
  always_comb begin
    unique case (mode)
      MODE_GT:  begin dbl = CH_GT;  k1 = KIND_GT;  end
      MODE_AMP: begin dbl = CH_AMP; k1 = KIND_AMP; end
      default:  begin dbl = CH_BAR; k1 = KIND_BAR; end
    endcase
  end

  // mode decode
  always_comb begin
    a_emit     = 1'b0;
    a_kind     = KIND_WORD;
    a_start    = cur_start;
    a_len      = LEN_W'(span);
    do_start   = 1'b0;
    mode_after = mode;
    unique case (mode)
      MODE_WORD: begin
        if (line_byte == CH_BSL) begin
          mode_after = MODE_WORD_ESC;
        end else if (line_byte == CH_NUL || is_space(line_byte) || is_symbol(line_byte)) begin
          a_emit   = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_WORD_ESC: begin
        if (line_byte == CH_NUL) begin
          a_emit   = 1'b1;
          do_start = 1'b1;
        end else begin
          mode_after = MODE_WORD;
        end
      end
      MODE_SQ, MODE_DQ, MODE_DQ_ESC: begin
        if (line_byte == CH_NUL) begin
          a_emit   = 1'b1;
          do_start = 1'b1;
        end else if (mode == MODE_DQ_ESC) begin
          mode_after = MODE_DQ;
        end else if ((mode == MODE_SQ && line_byte == CH_SQUOT) ||
                     (mode == MODE_DQ && line_byte == CH_DQUOT)) begin
          a_emit     = 1'b1;
          mode_after = MODE_IDLE;
        end else if (mode == MODE_DQ && line_byte == CH_BSL) begin
          mode_after = MODE_DQ_ESC;
        end
      end
      MODE_COMMENT: begin
        if (line_byte == CH_NUL) begin
          do_start = 1'b1;
        end else if (line_byte == CH_LF || line_byte == CH_CR) begin
          mode_after = MODE_IDLE;
        end
      end
      MODE_GT, MODE_AMP, MODE_BAR: begin
        a_emit = 1'b1;
        if (line_byte == dbl) begin
          a_kind     = token_kind_t'(k1 + KIND_W'(1));
          a_len      = LEN_W'(2);
          mode_after = MODE_IDLE;
        end else begin
          a_kind   = k1;
          a_len    = LEN_W'(1);
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase
  end

  // new token start
  always_comb begin
    b_emit      = 1'b0;
    b_kind      = KIND_WORD;
    b_len       = LEN_W'(1);
    s_mode      = MODE_IDLE;
    s_set_start = 1'b0;
    s_start_val = START_W'(spos);
    line_end    = 1'b0;
    if (line_byte == CH_NUL) begin
      b_emit   = 1'b1;
      b_kind   = KIND_END;
      b_len    = '0;
      line_end = 1'b1;
    end else if (!is_space(line_byte)) begin
      unique case (line_byte)
        CH_HASH:  s_mode = MODE_COMMENT;
        CH_GT:    begin s_mode = MODE_GT;  s_set_start = 1'b1; end
        CH_AMP:   begin s_mode = MODE_AMP; s_set_start = 1'b1; end
        CH_BAR:   begin s_mode = MODE_BAR; s_set_start = 1'b1; end
        CH_LT:    begin b_emit = 1'b1; b_kind = KIND_LT;   end
        CH_LPAR:  begin b_emit = 1'b1; b_kind = KIND_LP;   end
        CH_RPAR:  begin b_emit = 1'b1; b_kind = KIND_RP;   end
        CH_SEMI:  begin b_emit = 1'b1; b_kind = KIND_SEMI; end
        CH_SQUOT: begin
          s_mode = MODE_SQ; s_set_start = 1'b1; s_start_val = START_W'(qpos);
        end
        CH_DQUOT: begin
          s_mode = MODE_DQ; s_set_start = 1'b1; s_start_val = START_W'(qpos);
        end
        CH_BSL:   begin s_mode = MODE_WORD_ESC; s_set_start = 1'b1; end
        default:  begin s_mode = MODE_WORD;     s_set_start = 1'b1; end
      endcase
    end
  end

  // next state
  always_comb begin
    mode_next      = do_start ? s_mode : mode_after;
    cur_start_next = (do_start && s_set_start) ? s_start_val : cur_start;
    line_pos_next  = pos_adv;
    ovf_seen_next  = ovf_now;
    // end of line: back to the reset state
    if (do_start && line_end) begin
      mode_next      = MODE_IDLE;
      cur_start_next = '0;
      line_pos_next  = '0;
      ovf_seen_next  = 1'b0;
    end
  end

  // token outputs
  always_comb begin
    push.a_valid    = accept && a_emit;
    push.a.kind     = a_kind;
    push.a.start    = a_start;
    push.a.length   = a_len;
    push.a.overflow = ovf_now;
    push.a.last     = !(do_start && b_emit);
    push.b_valid    = accept && do_start && b_emit;
    push.b.kind     = b_kind;
    push.b.start    = START_W'(spos);
    push.b.length   = b_len;
    push.b.overflow = ovf_now;
    push.b.last     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      cur_start <= '0;
      line_pos  <= '0;
      ovf_seen  <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      cur_start <= cur_start_next;
      line_pos  <= line_pos_next;
      ovf_seen  <= ovf_seen_next;
    end
  end

endmodule

[rtl/slt_token_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_token_queue: token queue and output stage
// Takes up to two tokens per cycle from the lexer and presents them one per
// cycle on the output channel when ready, straight from its registers.
// ----------------------------------------------------------------------------
module slt_token_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  slt_pkg::token_push_t push,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slt_pkg::token_t      head
);
  import slt_pkg::*;

  token_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic [QCNT_W-1:0] n_push;
  logic              pop;
  logic [QPTR_W-1:0] b_ptr;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];
  // room for the worst case of two tokens from one byte
  assign space     = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  assign n_push     = QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid);
  assign count_next = count + n_push - QCNT_W'(pop);
  assign b_ptr      = push.a_valid ? wr_ptr + QPTR_W'(1) : wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      entries[wr_ptr] <= push.a;
    end
    if (push.b_valid) begin
      entries[b_ptr] <= push.b;
    end
  end

endmodule

[rtl/shell_command_line_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer_core: command line tokenizer
// Splits a byte stream of command lines into words and shell operators.
//
//   channel   dir   payload                                            beats
//   bytes     in    line_byte                                          1 / byte
//   tokens    out   token_kind token_start token_length overflow last  0..2 / byte
//
// One byte is taken per cycle while the queue has room; its tokens appear at the
// output from the next cycle on, one per cycle while the sink is ready. The rate
// is set by the lexer state machine, which decides each byte as it is taken, and
// by the four-entry token queue, which holds off input while fewer than two
// entries are free. Reset is synchronous and clears the lexer state and the queue.
// An output stall fills the queue and then stalls the input.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  slt_byte_if.sink    bytes,
  slt_token_if.source tokens
);
  import slt_pkg::*;

  token_push_t push;
  logic        space;
  token_t      head;

  slt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (bytes.valid),
    .line_byte   (bytes.line_byte),
    .ready       (bytes.ready),
    .queue_space (space),
    .push        (push)
  );

  slt_token_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .head      (head)
  );

  assign tokens.token_kind   = head.kind;
  assign tokens.token_start  = head.start;
  assign tokens.token_length = head.length;
  assign tokens.overflow     = head.overflow;
  assign tokens.last         = head.last;

endmodule

[rtl/slt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker: port-level checks of the tokenizer
// Watches the token channel and is bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [slt_pkg::KIND_W-1:0]  token_kind,
  input logic [slt_pkg::START_W-1:0] token_start,
  input logic [slt_pkg::LEN_W-1:0]   token_length,
  input logic                        last
);
  import slt_pkg::*;

  // nothing to show in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token offered right after reset");

  // end of line closes the transfers of its byte and has no length
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind == KIND_END) |-> (last && token_length == '0))
    else $error("end token not last or with length");

  // operators are one or two bytes long
  a_op_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind != KIND_WORD && token_kind != KIND_END)
      |-> (token_length == LEN_W'(1) || token_length == LEN_W'(2)))
    else $error("operator token with bad length");

  // the doubled operators are two bytes long
  a_double_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (token_kind == KIND_GTGT || token_kind == KIND_AND ||
                   token_kind == KIND_OR)) |-> token_length == LEN_W'(2))
    else $error("double operator with single length");

  // a stalled token holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(token_kind) &&
                                   $stable(token_start) && $stable(token_length)))
    else $error("stalled token changed");

endmodule

bind shell_command_line_tokenizer_core slt_checker u_slt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.token_kind),
  .token_start  (tokens.token_start),
  .token_length (tokens.token_length),
  .last         (tokens.last)
);
